>>> hw/rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int ID_W          = 16;
  localparam int VAL_W         = 32;

  localparam logic [ID_W-1:0] NO_FREE_ID = 16'hFFFF;

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_SET   = 3'd2;
  localparam logic [2:0] OP_RESET = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_FREE  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EXPIRE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  ident;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] count;
  } slot_data_t;

  typedef struct packed {
    logic             match;
    logic             active;
    logic             expire;
    logic             in_range;
    logic [VAL_W-1:0] next_count;
  } alu_res_t;

endpackage

>>> hw/rtl/ptt_slot_mem.sv
module ptt_slot_mem #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  ptt_pkg::slot_data_t wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output ptt_pkg::slot_data_t rdata
);
  import ptt_pkg::*;

  slot_data_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ptt_alu.sv
module ptt_alu (
  input  logic [ptt_pkg::VAL_W-1:0] count,
  input  logic [ptt_pkg::VAL_W-1:0] amount,
  input  logic [ptt_pkg::VAL_W-1:0] period,
  input  logic [ptt_pkg::ID_W-1:0]  ident,
  input  logic [ptt_pkg::ID_W-1:0]  key,
  input  logic [ptt_pkg::ID_W-1:0]  bound,
  output ptt_pkg::alu_res_t         res
);
  import ptt_pkg::*;

  logic [VAL_W:0] sum;

  always_comb begin
    // 33-bit sum: the count never wraps
    sum            = {1'b0, count} + {1'b0, amount};
    res.match      = (ident == key);
    res.active     = (period != '0);
    res.expire     = (sum >= {1'b0, period});
    res.in_range   = (ident <= bound);
    res.next_count = res.expire ? '0 : sum[VAL_W-1:0];
  end

endmodule

>>> hw/rtl/periodic_timer_table.sv
// Channel | Handshake              | Payload
// in      | in_tvalid / in_tready  | tuser: operation; tdata: timer_id, interval, tick_amount
// out     | out_tvalid / out_tready| tuser: kind; tdata: status, result_id; tlast: last
//
// An operation walks the occupied slots through a single-port slot memory with
// registered read, a read state and an execute state per slot, then for a
// free-id query a sweep of the used ids. No new request is taken until the
// reply has been loaded into the output register. Reset clears only the fill
// count and control; slot contents are never read before being written. A
// stalled output holds the scan at the slot whose expiry is waiting.
module periodic_timer_table #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // timer_id[15:0], interval[47:16], tick_amount[79:48]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], result_id[18:3], zero[23:19]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);
  import ptt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SWEEP, S_REPLY, S_TICK_END
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [ID_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0] ivl_r, ivl_nxt;
  logic [VAL_W-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [NUM_SLOTS:0] used_r, used_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_rid_r, out_rid_nxt;
  logic             out_last_r, out_last_nxt;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  slot_data_t       mem_wdata, mem_rdata;
  alu_res_t         alu;
  logic             out_free;

  ptt_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  ptt_alu u_alu (
    .count  (mem_rdata.count),
    .amount (amt_r),
    .period (mem_rdata.period),
    .ident  (mem_rdata.ident),
    .key    (key_r),
    .bound  (ID_W'(fill_r)),
    .res    (alu)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_rid_r, out_status_r};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    ivl_nxt    = ivl_r;
    amt_nxt    = amt_r;
    idx_nxt    = idx_r;
    wr_nxt     = wr_r;
    fill_nxt   = fill_r;
    used_nxt   = used_r;
    status_nxt = status_r;
    rid_nxt    = rid_r;

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r[IDX_W-1:0];
    mem_wdata = mem_rdata;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_rid_nxt    = out_rid_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          key_nxt    = in_tdata[15:0];
          ivl_nxt    = in_tdata[47:16];
          amt_nxt    = in_tdata[79:48];
          idx_nxt    = '0;
          wr_nxt     = '0;
          used_nxt   = '0;
          status_nxt = ST_OK;
          rid_nxt    = '0;
          if (in_tuser > OP_FREE || (in_tuser == OP_ADD && in_tdata[47:16] == '0)) begin
            status_nxt = ST_INVALID;
            state_nxt  = S_REPLY;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (idx_r == fill_r) begin
          // scan finished without a hit
          case (op_r)
            OP_ADD: begin
              if (fill_r == CNT_W'(NUM_SLOTS)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = fill_r[IDX_W-1:0];
                mem_wdata.ident  = key_r;
                mem_wdata.period = ivl_r;
                mem_wdata.count  = '0;
                fill_nxt        = fill_r + 1'b1;
              end
              state_nxt = S_REPLY;
            end
            OP_TICK: begin
              fill_nxt  = wr_r;
              state_nxt = S_TICK_END;
            end
            OP_FREE: begin
              idx_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            default: begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_REPLY;
            end
          endcase
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (alu.match) begin
              status_nxt = ST_DUP;
              state_nxt  = S_REPLY;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_READ;
            end
          end
          OP_DEL, OP_SET, OP_RESET: begin
            if (alu.match) begin
              mem_we          = 1'b1;
              mem_wdata.count = '0;
              if (op_r == OP_DEL) begin
                mem_wdata.period = '0;
              end else if (op_r == OP_SET) begin
                mem_wdata.period = ivl_r;
              end
              state_nxt = S_REPLY;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_READ;
            end
          end
          OP_TICK: begin
            if (!alu.active) begin
              // drop entries pending deletion
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_READ;
            end else if (!alu.expire || out_free) begin
              // compact in place: the write pointer never passes the read index
              mem_we          = 1'b1;
              mem_waddr       = wr_r[IDX_W-1:0];
              mem_wdata.count = alu.next_count;
              wr_nxt          = wr_r + 1'b1;
              idx_nxt         = idx_r + 1'b1;
              state_nxt       = S_READ;
              if (alu.expire) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_EXPIRE;
                out_status_nxt = ST_OK;
                out_rid_nxt    = mem_rdata.ident;
                out_last_nxt   = 1'b0;
              end
            end
          end
          OP_FREE: begin
            if (alu.in_range) begin
              used_nxt[mem_rdata.ident[CNT_W-1:0]] = 1'b1;
            end
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_READ;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SWEEP: begin
        if (!used_r[idx_r]) begin
          rid_nxt   = ID_W'(idx_r);
          state_nxt = S_REPLY;
        end else if (idx_r == fill_r) begin
          rid_nxt   = NO_FREE_ID;
          state_nxt = S_REPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = status_r;
          out_rid_nxt    = rid_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_TICK_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_TICK;
          out_status_nxt = ST_OK;
          out_rid_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      key_r        <= key_nxt;
      ivl_r        <= ivl_nxt;
      amt_r        <= amt_nxt;
      idx_r        <= idx_nxt;
      wr_r         <= wr_nxt;
      used_r       <= used_nxt;
      status_r     <= status_nxt;
      rid_r        <= rid_nxt;
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_rid_r    <= out_rid_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

endmodule
